>>> rtl/i2cee_pkg.sv
// Package for the serial EEPROM byte-access I2C master.
// Holds the request kinds, register indexes, field widths and the result record.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2cee_pkg;

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEVICE_SELECT = 2'd0;
   localparam logic [1:0] CSR_ACK_POLL_LIM  = 2'd1;
   localparam logic [1:0] CSR_WRITE_WAIT    = 2'd2;

   localparam int CsrIndexW = 2;
   localparam int CsrDataW  = 16;

   // configuration reset values
   localparam logic [7:0]  DEVICE_SELECT_RST = 8'hA0;
   localparam logic [7:0]  ACK_POLL_LIM_RST  = 8'd250;
   localparam logic [15:0] WRITE_WAIT_RST    = 16'd10000;

   // one result record
   typedef struct packed {
      logic       scl_release;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_error;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/i2cee_if.sv
// Valid/ready channel interfaces for requests and results of the EEPROM master.
// Has no dependencies; the result fields are declared one by one.
`timescale 1ns / 1ps
`default_nettype none

interface i2cee_req_if #(
   parameter int ADDRESS_BITS = 13
);
   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic [ADDRESS_BITS-1:0] mem_address;
   logic [7:0]              write_data;
   logic                    sda_level;

   modport source (output valid, kind, mem_address, write_data, sda_level, input ready);
   modport sink   (input valid, kind, mem_address, write_data, sda_level, output ready);
endinterface

interface i2cee_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_release;
   logic       sda_release;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       ack_error;

   modport source (output valid, scl_release, sda_release, busy_res, done_res, read_data,
                   ack_error, input ready);
   modport sink   (input valid, scl_release, sda_release, busy_res, done_res, read_data,
                   ack_error, output ready);
endinterface

`default_nettype wire

>>> rtl/i2c_eeprom_byte_access_master.sv
// I2C master for a serial EEPROM with a two-byte memory address: single-byte random
// read and single-byte write with write-recovery wait. Depends on i2cee_pkg and the
// channel interfaces in i2cee_if.sv.
//
// Every request transaction is either a one-microsecond tick or a read/write request
// and produces exactly one result transaction carrying the SCL/SDA levels to hold for
// the coming microsecond plus status. One transaction is taken per clock while the skid
// register is empty: the whole sequencer step is a single state register update, and
// its result is registered on acceptance. A two-entry output stage (result register
// plus skid register) keeps the request side open for one extra transaction while a
// result is stalled. Requests arriving while busy are dropped (a result is still
// given); ticks while idle leave both lines released. An acknowledge that stays high
// for more than ack_poll_limit ticks ends the transfer with a stop and sets ack_error.
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_access_master #(
   parameter int ADDRESS_BITS = 13
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   i2cee_req_if.sink                           req,
   i2cee_rsp_if.source                         rsp,
   input  wire logic                           csr_we,
   input  wire logic [i2cee_pkg::CsrIndexW-1:0] csr_index,
   input  wire logic [i2cee_pkg::CsrDataW-1:0]  csr_wdata
);

   // sequencer step codes
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_START_HI = 4'd1;
   localparam logic [3:0] ST_START_LO = 4'd2;
   localparam logic [3:0] ST_TX       = 4'd3;
   localparam logic [3:0] ST_ACK_REL  = 4'd4;
   localparam logic [3:0] ST_ACK_HIGH = 4'd5;
   localparam logic [3:0] ST_ACK_POLL = 4'd6;
   localparam logic [3:0] ST_RX_PRE   = 4'd7;
   localparam logic [3:0] ST_RX       = 4'd8;
   localparam logic [3:0] ST_NACK     = 4'd9;
   localparam logic [3:0] ST_STOP_LO  = 4'd10;
   localparam logic [3:0] ST_STOP_HI  = 4'd11;
   localparam logic [3:0] ST_WAIT     = 4'd12;

   // configuration registers
   logic [7:0]  dev_sel_ff;
   logic [7:0]  poll_lim_ff;
   logic [15:0] wait_us_ff;

   // sequencer state
   logic [3:0]              step_ff, step_in;
   logic [15:0]             timer_ff, timer_in;
   logic [3:0]              bit_cnt_ff, bit_cnt_in;
   logic [7:0]              shift_ff, shift_in;
   logic [7:0]              poll_ff, poll_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [7:0]              data_ff, data_in;
   logic                    is_read_ff, is_read_in;
   logic [7:0]              rx_byte_ff, rx_byte_in;
   logic                    err_ff, err_in;
   logic [2:0]              stage_ff, stage_in;
   logic                    done_now;

   // output stage
   i2cee_pkg::rsp_type out_ff, skid_ff, rsp_new;
   logic               out_vld_ff, skid_vld_ff;
   logic               req_fire, out_load;
   logic [15:0]        addr_wide;
   logic [15:0]        timer_inc;

   assign req.ready = !skid_vld_ff;
   assign req_fire  = req.valid && req.ready;
   assign out_load  = rsp.ready || !out_vld_ff;
   assign addr_wide = 16'(addr_ff);
   assign timer_inc = 16'(timer_ff + 16'd1);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_sel_ff  <= i2cee_pkg::DEVICE_SELECT_RST;
         poll_lim_ff <= i2cee_pkg::ACK_POLL_LIM_RST;
         wait_us_ff  <= i2cee_pkg::WRITE_WAIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            i2cee_pkg::CSR_DEVICE_SELECT: dev_sel_ff  <= csr_wdata[7:0];
            i2cee_pkg::CSR_ACK_POLL_LIM:  poll_lim_ff <= csr_wdata[7:0];
            i2cee_pkg::CSR_WRITE_WAIT:    wait_us_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // sequencer next state for one transaction
   always_comb begin
      step_in    = step_ff;
      timer_in   = timer_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      addr_in    = addr_ff;
      data_in    = data_ff;
      is_read_in = is_read_ff;
      rx_byte_in = rx_byte_ff;
      err_in     = err_ff;
      stage_in   = stage_ff;
      done_now   = 1'b0;
      if (req.kind == i2cee_pkg::KIND_TICK) begin
         if (step_ff != ST_IDLE) begin
            timer_in = timer_inc;
            case (step_ff)
               ST_START_HI: begin
                  if (timer_ff >= 16'd3) begin
                     step_in  = ST_START_LO;
                     timer_in = '0;
                  end
               end
               ST_START_LO: begin
                  if (timer_ff >= 16'd3) begin
                     step_in    = ST_TX;
                     timer_in   = '0;
                     bit_cnt_in = '0;
                     if (stage_ff == 3'd0) begin
                        shift_in = dev_sel_ff;
                     end else begin
                        stage_in = 3'd3;
                        shift_in = 8'(dev_sel_ff + 8'd1);
                     end
                  end
               end
               ST_TX: begin
                  if (timer_ff >= 16'd5) begin
                     shift_in   = {shift_ff[6:0], 1'b0};
                     bit_cnt_in = 4'(bit_cnt_ff + 4'd1);
                     timer_in   = '0;
                     if (bit_cnt_ff >= 4'd7) begin
                        step_in = ST_ACK_REL;
                     end
                  end
               end
               ST_ACK_REL: begin
                  step_in  = ST_ACK_HIGH;
                  timer_in = '0;
               end
               ST_ACK_HIGH: begin
                  poll_in  = '0;
                  step_in  = ST_ACK_POLL;
                  timer_in = '0;
               end
               ST_ACK_POLL: begin
                  if (!req.sda_level) begin
                     // acknowledged: move on to the next byte of the sequence
                     stage_in = 3'(stage_ff + 3'd1);
                     timer_in = '0;
                     case (stage_ff)
                        3'd0: begin
                           shift_in   = addr_wide[15:8];
                           bit_cnt_in = '0;
                           step_in    = ST_TX;
                        end
                        3'd1: begin
                           shift_in   = addr_wide[7:0];
                           bit_cnt_in = '0;
                           step_in    = ST_TX;
                        end
                        3'd2: begin
                           if (is_read_ff) begin
                              step_in = ST_START_HI;
                           end else begin
                              shift_in   = data_ff;
                              bit_cnt_in = '0;
                              step_in    = ST_TX;
                           end
                        end
                        default: begin
                           if (is_read_ff) begin
                              shift_in   = '0;
                              bit_cnt_in = '0;
                              step_in    = ST_RX_PRE;
                           end else begin
                              step_in = ST_STOP_LO;
                           end
                        end
                     endcase
                  end else if (poll_ff >= poll_lim_ff) begin
                     err_in   = 1'b1;
                     step_in  = ST_STOP_LO;
                     timer_in = '0;
                  end else begin
                     poll_in = 8'(poll_ff + 8'd1);
                  end
               end
               ST_RX_PRE: begin
                  if (timer_ff >= 16'd3) begin
                     step_in  = ST_RX;
                     timer_in = '0;
                  end
               end
               ST_RX: begin
                  // sample on the third high tick
                  if (timer_ff == 16'd6) begin
                     shift_in = {shift_ff[6:0], req.sda_level};
                  end
                  if (timer_ff >= 16'd9) begin
                     bit_cnt_in = 4'(bit_cnt_ff + 4'd1);
                     timer_in   = '0;
                     if (bit_cnt_ff >= 4'd7) begin
                        rx_byte_in = shift_ff;
                        step_in    = ST_NACK;
                     end
                  end
               end
               ST_NACK: begin
                  if (timer_ff >= 16'd3) begin
                     step_in  = ST_STOP_LO;
                     timer_in = '0;
                  end
               end
               ST_STOP_LO: begin
                  if (timer_ff >= 16'd3) begin
                     step_in  = ST_STOP_HI;
                     timer_in = '0;
                  end
               end
               ST_STOP_HI: begin
                  if (timer_ff >= 16'd3) begin
                     timer_in = '0;
                     if (is_read_ff || err_ff || (wait_us_ff == 16'd0)) begin
                        step_in  = ST_IDLE;
                        done_now = 1'b1;
                     end else begin
                        step_in = ST_WAIT;
                     end
                  end
               end
               ST_WAIT: begin
                  if (({1'b0, timer_ff} + 17'd1) >= {1'b0, wait_us_ff}) begin
                     step_in  = ST_IDLE;
                     timer_in = '0;
                     done_now = 1'b1;
                  end
               end
               default: begin
                  step_in  = ST_IDLE;
                  timer_in = '0;
               end
            endcase
         end
      end else if ((req.kind == i2cee_pkg::KIND_READ || req.kind == i2cee_pkg::KIND_WRITE)
                   && step_ff == ST_IDLE) begin
         // new transfer request
         addr_in    = req.mem_address;
         data_in    = req.write_data;
         is_read_in = (req.kind == i2cee_pkg::KIND_READ);
         err_in     = 1'b0;
         stage_in   = '0;
         bit_cnt_in = '0;
         poll_in    = '0;
         step_in    = ST_START_HI;
         timer_in   = '0;
      end
   end

   // line levels for the coming microsecond
   always_comb begin
      rsp_new.scl_release = 1'b1;
      rsp_new.sda_release = 1'b1;
      case (step_in)
         ST_START_LO: rsp_new.sda_release = 1'b0;
         ST_TX: begin
            rsp_new.scl_release = (timer_in >= 16'd2) && (timer_in < 16'd4);
            rsp_new.sda_release = shift_in[7];
         end
         ST_ACK_REL: rsp_new.scl_release = 1'b0;
         ST_RX_PRE:  rsp_new.scl_release = 1'b0;
         ST_RX:      rsp_new.scl_release = (timer_in >= 16'd4) && (timer_in < 16'd8);
         ST_NACK:    rsp_new.scl_release = (timer_in >= 16'd2);
         ST_STOP_LO: begin
            rsp_new.scl_release = 1'b0;
            rsp_new.sda_release = 1'b0;
         end
         default: begin
         end
      endcase
      rsp_new.busy_res  = (step_in != ST_IDLE);
      rsp_new.done_res  = done_now;
      rsp_new.read_data = rx_byte_in;
      rsp_new.ack_error = err_in;
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_IDLE;
         timer_ff   <= '0;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         poll_ff    <= '0;
         addr_ff    <= '0;
         data_ff    <= '0;
         is_read_ff <= 1'b0;
         rx_byte_ff <= '0;
         err_ff     <= 1'b0;
         stage_ff   <= '0;
      end else if (req_fire) begin
         step_ff    <= step_in;
         timer_ff   <= timer_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         poll_ff    <= poll_in;
         addr_ff    <= addr_in;
         data_ff    <= data_in;
         is_read_ff <= is_read_in;
         rx_byte_ff <= rx_byte_in;
         err_ff     <= err_in;
         stage_ff   <= stage_in;
      end
   end

   // result register and skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_vld_ff <= skid_vld_ff || req_fire;
         end
         if (skid_vld_ff && out_load) begin
            skid_vld_ff <= req_fire;
         end else if (!skid_vld_ff && !out_load && req_fire) begin
            skid_vld_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= skid_vld_ff ? skid_ff : rsp_new;
      end
      if (req_fire && (skid_vld_ff || !out_load)) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp.valid       = out_vld_ff;
   assign rsp.scl_release = out_ff.scl_release;
   assign rsp.sda_release = out_ff.sda_release;
   assign rsp.busy_res    = out_ff.busy_res;
   assign rsp.done_res    = out_ff.done_res;
   assign rsp.read_data   = out_ff.read_data;
   assign rsp.ack_error   = out_ff.ack_error;

   // checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register holds a result while the result register is empty");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.done_res) |-> !out_ff.busy_res)
      else $error("transfer reported done while still busy");

   a_bit_cnt_range: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= 4'd8)
      else $error("bit counter past one byte");

   a_tx_timer_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == ST_TX) |-> (timer_ff < 16'd6))
      else $error("transmit bit timer overran");

endmodule

`default_nettype wire
